// ===== hw/rtl/wsli_pkg.sv =====
// Shared constants for the wake-time sorted list insert block.
// Holds field widths, the empty-link marker and the stream packing layout.
// No dependencies.
package wsli_pkg;

    // Marker for "no entry": an empty list head or the end of the list.
    localparam logic [7:0] NIL_SLOT = 8'hff;

    // Input field widths.
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned TICKS_W = 32;

    // Result field widths.
    localparam int unsigned LINK_W = 8;

    // Packed stream widths, padded to whole bytes.
    localparam int unsigned S_DATA_W = 104;
    localparam int unsigned M_DATA_W = 24;

    // Bit positions of the input fields inside s_tdata.
    localparam int unsigned START_LSB = INDEX_W;
    localparam int unsigned TICKS_LSB = INDEX_W + TIME_W;

    // Bit position of the was_empty flag inside m_tdata.
    localparam int unsigned EMPTY_BIT = 2 * LINK_W;

endpackage

// ===== hw/rtl/wake_time_sorted_list_insert.sv =====
// Inserts one entry per transaction into a wait list ordered by wake time and
// kept as a linked list over two tables: wake times and next links, each in a
// RAM with a registered read. The wake time is start_time + wait_ticks (64-bit
// wrap), or all ones when wait_ticks is all ones. An insert with an out-of-range
// slot goes straight to the result; one into an empty list stores the wake time
// and link and then reports. Otherwise the block stores the wake time, reads the
// head, walks the list (one entry per cycle, at most ENTRIES entries, through the
// read address shared by both RAMs), patches the links, using ST_LINK unless the
// entry becomes the new head, and reports. A result that the consumer has not yet
// taken holds the insert in its last step. One transaction is in work at a time.
// Depends on wsli_pkg and wsli_ram.
module wake_time_sorted_list_insert #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, from bit 0: entry_index[5:0], start_time[63:0], wait_ticks[31:0].
    input  logic [wsli_pkg::S_DATA_W-1:0] s_tdata,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, from bit 0: head_index[7:0], successor_index[7:0], was_empty.
    output logic [wsli_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = AW;
    localparam logic [7:0]  ENT8 = 8'(ENTRIES);
    localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAKE,
        ST_READ,
        ST_WALK,
        ST_LINK,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]                    head_reg, head_next;
    logic [7:0]                    slot_reg, slot_next;
    logic [wsli_pkg::TIME_W-1:0]   wake_reg, wake_next;
    logic                          empty_reg, empty_next;
    logic [7:0]                    cur_reg, cur_next;
    logic [7:0]                    prev_reg, prev_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [7:0]                    succ_reg, succ_next;
    logic [7:0]                    lnk_addr_reg, lnk_addr_next;
    logic [7:0]                    lnk_data_reg, lnk_data_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [wsli_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM ports.
    logic                          wake_we;
    logic [wsli_pkg::TIME_W-1:0]   wake_rdata;
    logic                          link_we;
    logic [AW-1:0]                 link_waddr;
    logic [7:0]                    link_wdata;
    logic [7:0]                    link_rdata;
    logic [AW-1:0]                 rd_addr;

    // Input field split.
    logic [7:0]                    in_slot;
    logic [wsli_pkg::TIME_W-1:0]   in_start;
    logic [wsli_pkg::TICKS_W-1:0]  in_ticks;
    logic [wsli_pkg::TIME_W-1:0]   in_wake;
    logic                          accept;
    logic                          head_empty;
    logic                          hit;
    logic                          walk_end;

    assign in_slot  = {2'b00, s_tdata[wsli_pkg::INDEX_W-1:0]};
    assign in_start = s_tdata[wsli_pkg::START_LSB +: wsli_pkg::TIME_W];
    assign in_ticks = s_tdata[wsli_pkg::TICKS_LSB +: wsli_pkg::TICKS_W];
    assign in_wake  = (in_ticks == {wsli_pkg::TICKS_W{1'b1}}) ? {wsli_pkg::TIME_W{1'b1}}
                    : in_start + {32'd0, in_ticks};

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign head_empty = (head_reg >= ENT8);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // Walk decisions on the entry whose read data has just arrived.
    assign hit      = (wake_rdata >= wake_reg);
    assign walk_end = (link_rdata >= ENT8) || (cnt_reg == CNT_LAST);

    // The walk follows the link just read; every other read addresses cur_reg.
    assign rd_addr = (state_reg == ST_WALK) ? link_rdata[AW-1:0] : cur_reg[AW-1:0];

    wsli_ram #(
        .WIDTH (wsli_pkg::TIME_W),
        .DEPTH (ENTRIES)
    ) u_wake_ram (
        .aclk  (aclk),
        .we    (wake_we),
        .waddr (slot_reg[AW-1:0]),
        .wdata (wake_reg),
        .raddr (rd_addr),
        .rdata (wake_rdata)
    );

    wsli_ram #(
        .WIDTH (wsli_pkg::LINK_W),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    // Sequencer: store the wake time, walk the list, patch the links, report; an out-of-range slot is only reported.
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        slot_next     = slot_reg;
        wake_next     = wake_reg;
        empty_next    = empty_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        cnt_next      = cnt_reg;
        succ_next     = succ_reg;
        lnk_addr_next = lnk_addr_reg;
        lnk_data_next = lnk_data_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wake_we       = 1'b0;
        link_we       = 1'b0;
        link_waddr    = slot_reg[AW-1:0];
        link_wdata    = wsli_pkg::NIL_SLOT;

        // The consumer takes the result register.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    slot_next  = in_slot;
                    wake_next  = in_wake;
                    empty_next = head_empty;
                    if (in_slot >= ENT8) begin
                        succ_next  = wsli_pkg::NIL_SLOT;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_WAKE;
                    end
                end
            end
            ST_WAKE: begin
                wake_we = 1'b1;
                if (empty_reg) begin
                    // The entry becomes the only element of the list.
                    link_we    = 1'b1;
                    head_next  = slot_reg;
                    succ_next  = wsli_pkg::NIL_SLOT;
                    state_next = ST_DONE;
                end else begin
                    cur_next   = head_reg;
                    prev_next  = head_reg;
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // Read of the head goes out after the wake write has landed.
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (hit) begin
                    // Link in front of the current entry.
                    link_we    = 1'b1;
                    link_wdata = cur_reg;
                    if (cur_reg == head_reg) begin
                        head_next  = slot_reg;
                        succ_next  = cur_reg;
                        state_next = ST_DONE;
                    end else begin
                        lnk_addr_next = prev_reg;
                        lnk_data_next = slot_reg;
                        succ_next     = (prev_reg == slot_reg) ? slot_reg : cur_reg;
                        state_next    = ST_LINK;
                    end
                end else if (walk_end) begin
                    // Append after the current entry; the new entry is the tail.
                    link_we       = 1'b1;
                    link_waddr    = cur_reg[AW-1:0];
                    link_wdata    = slot_reg;
                    lnk_addr_next = slot_reg;
                    lnk_data_next = wsli_pkg::NIL_SLOT;
                    succ_next     = wsli_pkg::NIL_SLOT;
                    state_next    = ST_LINK;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_LINK: begin
                link_we    = 1'b1;
                link_waddr = lnk_addr_reg[AW-1:0];
                link_wdata = lnk_data_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, empty_reg, succ_reg, head_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, list head, working registers and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= wsli_pkg::NIL_SLOT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        slot_reg     <= slot_next;
        wake_reg     <= wake_next;
        empty_reg    <= empty_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        cnt_reg      <= cnt_next;
        succ_reg     <= succ_next;
        lnk_addr_reg <= lnk_addr_next;
        lnk_data_reg <= lnk_data_next;
        m_tdata_reg  <= m_tdata_next;
    end

`ifndef SYNTH
    // The list head is either a valid slot or the empty marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg < ENT8) || (head_reg == wsli_pkg::NIL_SLOT))
        else $error("list head holds an invalid slot");

    // Link writes only ever target a slot inside the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        link_we |-> (32'(link_waddr) < ENTRIES))
        else $error("link write outside the table");

    // The wake time is stored in the cycle after an in-range slot is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_slot < ENT8)) |=> wake_we)
        else $error("wake time not stored after accept");

    // A walk step always reads the link it is about to follow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && !hit && !walk_end) |=>
            (state_reg == ST_WALK && cur_reg == $past(link_rdata)))
        else $error("walk did not advance along the list");

    // A result with a successor other than the tail marker names a valid slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((m_tdata_reg[15:8] < ENT8) ||
                          (m_tdata_reg[15:8] == wsli_pkg::NIL_SLOT)))
        else $error("result successor is an invalid slot");
`endif

endmodule

// ===== hw/rtl/wsli_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the wake time table and the link table of the insert block.
// No dependencies.
module wsli_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the wake-time sorted list insert block.
// It predicts each insert result from its own copy of the list state.
// Depends on wsli_pkg and wake_time_sorted_list_insert.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned ENTRIES      = 64;
    // A walk over the whole table plus the fixed overhead of one insert.
    localparam int unsigned DRAIN_CYCLES = ENTRIES + 8;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned LONG_HOLD    = 400;

    // Expected result of one insert.
    typedef struct packed {
        logic [wsli_pkg::LINK_W-1:0] head_index;
        logic [wsli_pkg::LINK_W-1:0] successor_index;
        logic                        was_empty;
    } insert_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [wsli_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [wsli_pkg::M_DATA_W-1:0] m_tdata;

    // Predicted list state: wake time and next link per slot, and the head.
    logic [wsli_pkg::TIME_W-1:0] slot_wake [ENTRIES];
    logic [wsli_pkg::LINK_W-1:0] slot_next [ENTRIES];
    logic [wsli_pkg::LINK_W-1:0] list_head;

    insert_result_t pending_inserts[$];
    int unsigned    mismatch_count = 0;
    int unsigned    burst_left = 0;
    int unsigned    rx_hold_cycles = 0;

    wake_time_sorted_list_insert #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Insert one slot into the predicted list and return the result it gives.
    // A 6-bit index never reaches past the 64-entry table, so the slot is
    // always in range.
    function automatic insert_result_t insert_wake_time(
        input logic [wsli_pkg::INDEX_W-1:0] slot,
        input logic [wsli_pkg::TIME_W-1:0]  start_time,
        input logic [wsli_pkg::TICKS_W-1:0] wait_ticks
    );
        insert_result_t              res;
        logic [wsli_pkg::TIME_W-1:0] wake;
        logic [wsli_pkg::LINK_W-1:0] slot_id;
        logic [wsli_pkg::LINK_W-1:0] cur;
        logic [wsli_pkg::LINK_W-1:0] prev;
        logic [wsli_pkg::LINK_W-1:0] nxt;
        int unsigned                 n;
        bit                          done;
        slot_id       = {2'b00, slot};
        res.was_empty = (list_head >= ENTRIES);
        wake = (wait_ticks == '1) ? '1 : start_time + wsli_pkg::TIME_W'(wait_ticks);
        slot_wake[slot] = wake;
        if (res.was_empty) begin
            list_head       = slot_id;
            slot_next[slot] = wsli_pkg::NIL_SLOT;
        end else begin
            cur  = list_head;
            prev = cur;
            done = 1'b0;
            // Walk at most ENTRIES entries; a slot inserted twice can make a ring.
            for (n = 0; n < ENTRIES && !done; n++) begin
                if (slot_wake[cur] >= wake) begin
                    slot_next[slot] = cur;
                    if (cur == list_head)
                        list_head = slot_id;
                    else
                        slot_next[prev] = slot_id;
                    done = 1'b1;
                end else begin
                    nxt = slot_next[cur];
                    if (nxt >= ENTRIES || n + 1 >= ENTRIES) begin
                        slot_next[cur]  = slot_id;
                        slot_next[slot] = wsli_pkg::NIL_SLOT;
                        done = 1'b1;
                    end else begin
                        prev = cur;
                        cur  = nxt;
                    end
                end
            end
        end
        res.head_index      = list_head;
        res.successor_index = slot_next[slot];
        return res;
    endfunction

    // Offer one insert and hold it until the block takes it. The sender works
    // in bursts; a random gap follows the end of each burst.
    task automatic send_item(
        input logic [wsli_pkg::INDEX_W-1:0] slot,
        input logic [wsli_pkg::TIME_W-1:0]  start_time,
        input logic [wsli_pkg::TICKS_W-1:0] wait_ticks
    );
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, wait_ticks, start_time, slot};
        do @(posedge aclk); while (!s_tready);
        pending_inserts.push_back(insert_wake_time(slot, start_time, wait_ticks));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stop offering and wait until every expected result has come, then let
    // the block settle for one full walk.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_inserts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Empty list, head, middle and tail inserts, and ties at the head.
    task automatic test_ordering();
        send_item(6'd0, 64'd0, 32'd0);
        send_item(6'd5, 64'd0, 32'd100);
        send_item(6'd6, 64'd1000, 32'd0);
        send_item(6'd7, 64'd500, 32'd0);
        send_item(6'd8, 64'd0, 32'd0);
        send_item(6'd9, 64'h8000_0000_0000_0000, 32'd5);
        send_item(6'd10, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        send_item(6'd11, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    endtask

    // Wait-forever entries, ties between them, and 64-bit wrap of the sum.
    task automatic test_wrap_and_never();
        send_item(6'd63, '1, '1);
        send_item(6'd3, 64'd0, '1);
        send_item(6'd1, '1, 32'd1);
        send_item(6'd2, '1, 32'hFFFF_FFFE);
        send_item(6'd12, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFE);
    endtask

    // Slots that are already listed are inserted again, which can close a ring
    // and make the walk run into its length limit.
    task automatic test_reinsert_listed();
        send_item(6'd5, 64'd0, 32'd0);
        send_item(6'd63, 64'd0, 32'd2000);
        send_item(6'd20, 64'hFFFF_FFFF_FFFF_FFF0, 32'd1);
        send_item(6'd8, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0);
        send_item(6'd21, 64'd0, 32'd7);
    endtask

    // Random inserts, weighted toward close wake times so that ties and
    // middle inserts are common.
    task automatic test_random_inserts(input int unsigned count);
        logic [wsli_pkg::TIME_W-1:0]  start_time;
        logic [wsli_pkg::TICKS_W-1:0] wait_ticks;
        for (int unsigned i = 0; i < count; i++) begin
            start_time = {$urandom, $urandom};
            wait_ticks = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    start_time = 64'h1000 + $urandom_range(0, 31);
                    wait_ticks = $urandom_range(0, 15);
                end
                4: wait_ticks = '1;
                5: start_time = '1 - $urandom_range(0, 255);
                6: wait_ticks = '0;
                7: wait_ticks = 32'hFFFF_FFFE;
                default: ;
            endcase
            send_item(6'($urandom_range(0, ENTRIES - 1)), start_time, wait_ticks);
        end
    endtask

    // The receiver holds off for a long stretch while inserts keep coming,
    // so the block fills up and stalls its input.
    task automatic test_output_backpressure(input int unsigned count);
        rx_hold_cycles = LONG_HOLD;
        test_random_inserts(count);
    endtask

    // Receiver: a long hold when one is requested, otherwise one of four stall
    // patterns, which rx_mode picks at random.
    int unsigned rx_cycle = 0;
    int unsigned rx_mode  = 0;
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 128 == 0)
            rx_mode = $urandom_range(0, 3);
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= rx_cycle[0];
            endcase
        end
    end

    task automatic check_field(input string name, input int unsigned expected,
                               input int unsigned actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Compare each result transaction with the oldest expected insert result.
    always @(posedge aclk) begin
        insert_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_inserts.size() == 0) begin
                $display("%0t: unexpected result: head_index %0d, successor_index %0d",
                         $time, m_tdata[7:0], m_tdata[15:8]);
                mismatch_count++;
            end else begin
                exp_res = pending_inserts.pop_front();
                check_field("head_index", exp_res.head_index, m_tdata[7:0]);
                check_field("successor_index", exp_res.successor_index, m_tdata[15:8]);
                check_field("was_empty", exp_res.was_empty,
                            m_tdata[wsli_pkg::EMPTY_BIT]);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        list_head = wsli_pkg::NIL_SLOT;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ordering();
        test_wrap_and_never();
        test_reinsert_listed();
        wait_drained();
        test_random_inserts(600);
        wait_drained();
        test_output_backpressure(150);
        wait_drained();
        test_random_inserts(680);
        wait_drained();
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
